/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/adat_pkg.sv */
// ---------------------------------------------------------------------------
// adat_pkg
// Frame layout constants, types and the byte-to-token mapping.
// ---------------------------------------------------------------------------
package adat_pkg;

    localparam int unsigned NUM_CH      = 8;
    localparam int unsigned SAMPLE_W    = 24;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NUM_WORDS   = 8;
    localparam int unsigned FRAME_W     = WORD_W * NUM_WORDS;
    localparam int unsigned HDR_W       = 16;
    localparam int unsigned TOKEN_W     = 10;
    localparam int unsigned CNT_W       = $clog2(NUM_WORDS);

    localparam logic [HDR_W-1:0] HDR_BITS = 16'h8010;

    typedef logic [WORD_W-1:0]                  word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0]   word_arr_t;
    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0]    sample_arr_t;
    typedef logic [FRAME_W-1:0]                 frame_t;

    // A 1, the high nibble, a 1, then the low nibble.
    function automatic logic [TOKEN_W-1:0] make_token(input logic [7:0] b);
        make_token = {1'b1, b[7:4], 1'b1, b[3:0]};
    endfunction

endpackage

/* design/adat_enc_lane.sv */
// ---------------------------------------------------------------------------
// adat_enc_lane
// NRZI scan of one 32-bit slice of the frame, starting from a low level.
// ---------------------------------------------------------------------------
module adat_enc_lane (
    input  adat_pkg::word_t raw,
    output adat_pkg::word_t scan,
    output logic            parity
);
    import adat_pkg::*;

    // Bit 31 goes out first: each level is the running XOR from bit 31 down.
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            scan[i] = ^(raw >> i);
        end
    end

    assign parity = scan[0];

endmodule

/* design/adat_enc_merge.sv */
// ---------------------------------------------------------------------------
// adat_enc_merge
// Chains lane parities from the running line level and fixes up each word.
// ---------------------------------------------------------------------------
module adat_enc_merge (
    input  adat_pkg::word_arr_t          scan,
    input  logic [adat_pkg::NUM_WORDS-1:0] parity,
    input  logic                         level_in,
    output adat_pkg::word_arr_t          words,
    output logic                         level_out
);
    import adat_pkg::*;

    logic [NUM_WORDS:0] carry;

    always_comb begin
        carry[0] = level_in;
        for (int k = 0; k < NUM_WORDS; k++) begin
            carry[k+1] = carry[k] ^ parity[k];
            words[k]   = scan[k] ^ {WORD_W{carry[k]}};
        end
    end

    assign level_out = carry[NUM_WORDS];

endmodule

/* design/adat_frame_encoder_unit.sv */
// ---------------------------------------------------------------------------
// adat_frame_encoder_unit
// ADAT frame encoder: eight 24-bit samples in, eight 32-bit NRZI words out.
// ---------------------------------------------------------------------------
//  Channel | Ports                              | Moves
//  --------+------------------------------------+-------------------------------
//  input   | s_valid s_ready s_sample_0..7      | one frame request (8 samples)
//  result  | m_valid m_ready m_line_word        | one line word, eight per frame
//          | m_frame_end                        |
//
//  The result port sends one word per cycle while m_ready is high, and that
//  sets the throughput. Eight lanes scan the frame in the accept cycle; the
//  merge runs as the frame moves into the output buffer. A frame passes the
//  lane register, then the output buffer, before its first word goes out.
//  Reset sets the line level low. A stalled result port holds the buffer;
//  one more frame waits in the lane register, after which s_ready drops.
// ---------------------------------------------------------------------------
module adat_frame_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_sample_0,
    input  logic [23:0] s_sample_1,
    input  logic [23:0] s_sample_2,
    input  logic [23:0] s_sample_3,
    input  logic [23:0] s_sample_4,
    input  logic [23:0] s_sample_5,
    input  logic [23:0] s_sample_6,
    input  logic [23:0] s_sample_7,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_line_word,
    output logic        m_frame_end
);
    import adat_pkg::*;

    sample_arr_t            samples;
    frame_t                 frame_bits;
    word_arr_t              raw_words;
    word_arr_t              lane_scan;
    logic [NUM_WORDS-1:0]   lane_par;

    word_arr_t              a_scan_reg;
    logic [NUM_WORDS-1:0]   a_par_reg;
    logic                   a_valid_reg;

    word_arr_t              merged;
    logic                   level_next;

    word_arr_t              b_words_reg;
    logic                   b_valid_reg;
    logic [CNT_W-1:0]       b_cnt_reg;
    logic                   line_level_reg;

    logic                   s_fire;
    logic                   m_fire;
    logic                   last_out;
    logic                   load;

    assign samples = {s_sample_7, s_sample_6, s_sample_5, s_sample_4,
                      s_sample_3, s_sample_2, s_sample_1, s_sample_0};

    // Header, then three tokens per channel, high byte first.
    always_comb begin
        frame_bits = '0;
        frame_bits[FRAME_W-1 -: HDR_W] = HDR_BITS;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int j = 0; j < 3; j++) begin
                frame_bits[FRAME_W-1-HDR_W-(3*ch+j)*TOKEN_W -: TOKEN_W] =
                    make_token(samples[ch][SAMPLE_W-1-8*j -: 8]);
            end
        end
    end

    generate
        for (genvar k = 0; k < NUM_WORDS; k++) begin : g_lane
            assign raw_words[k] = frame_bits[FRAME_W-1-k*WORD_W -: WORD_W];
            adat_enc_lane u_lane (
                .raw    (raw_words[k]),
                .scan   (lane_scan[k]),
                .parity (lane_par[k])
            );
        end
    endgenerate

    adat_enc_merge u_merge (
        .scan      (a_scan_reg),
        .parity    (a_par_reg),
        .level_in  (line_level_reg),
        .words     (merged),
        .level_out (level_next)
    );

    assign m_valid     = b_valid_reg;
    assign m_line_word = b_words_reg[0];
    assign m_frame_end = (b_cnt_reg == CNT_W'(NUM_WORDS - 1));
    assign m_fire      = m_valid && m_ready;
    assign last_out    = m_fire && m_frame_end;
    assign load        = a_valid_reg && (!b_valid_reg || last_out);
    assign s_ready     = !a_valid_reg || load;
    assign s_fire      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            b_cnt_reg      <= '0;
            line_level_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                a_valid_reg <= 1'b1;
            end else if (load) begin
                a_valid_reg <= 1'b0;
            end

            if (load) begin
                b_valid_reg    <= 1'b1;
                b_cnt_reg      <= '0;
                line_level_reg <= level_next;
            end else if (last_out) begin
                b_valid_reg <= 1'b0;
                b_cnt_reg   <= '0;
            end else if (m_fire) begin
                b_cnt_reg <= b_cnt_reg + 1'b1;
            end
        end
    end

    // Payload: capture lane results, load merged words, shift on each accepted word.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_scan_reg <= lane_scan;
            a_par_reg  <= lane_par;
        end
        if (load) begin
            b_words_reg <= merged;
        end else if (m_fire) begin
            for (int k = 0; k < NUM_WORDS - 1; k++) begin
                b_words_reg[k] <= b_words_reg[k+1];
            end
            b_words_reg[NUM_WORDS-1] <= '0;
        end
    end

`include "assert_macros.svh"

    `ASSERT_HOLDS(a_load_free, aclk, aresetn, !load || !b_valid_reg || last_out)
    `ASSERT_NEXT(a_level_hold, aclk, aresetn, !load, $stable(line_level_reg))
    `ASSERT_NEXT(a_frame_drain, aclk, aresetn, last_out && !load, !m_valid)
    `ASSERT_NEXT(a_input_held, aclk, aresetn, s_fire, a_valid_reg)

endmodule

/* tb/adat_line_checker.sv */
// ---------------------------------------------------------------------------
// adat_line_checker
// Watches both channels of the ADAT frame encoder. Each accepted frame
// request is coded into eight NRZI line words. Every returned word is
// compared against the oldest word still due.
// ---------------------------------------------------------------------------
module adat_line_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [23:0] s_sample_0,
    input  logic [23:0] s_sample_1,
    input  logic [23:0] s_sample_2,
    input  logic [23:0] s_sample_3,
    input  logic [23:0] s_sample_4,
    input  logic [23:0] s_sample_5,
    input  logic [23:0] s_sample_6,
    input  logic [23:0] s_sample_7,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_line_word,
    input  logic        m_frame_end,
    output int          mismatch_count,
    output int          words_due
);
    import adat_pkg::*;

    typedef struct packed {
        word_t line_word;
        logic  frame_end;
    } line_beat_t;

    line_beat_t  beats_due [$];
    logic        nrzi_level = 1'b0;
    sample_arr_t frame_in;

    assign frame_in = {s_sample_7, s_sample_6, s_sample_5, s_sample_4,
                       s_sample_3, s_sample_2, s_sample_1, s_sample_0};

    // Build the raw frame bit stream, run it through the NRZI coder and queue
    // the eight words. The line level carries over to the next frame.
    function automatic void encode_frame(input sample_arr_t smp);
        frame_t     raw;
        frame_t     coded;
        logic [7:0] b;
        int         idx;
        line_beat_t beat;
        raw = '0;
        coded = '0;
        raw[FRAME_W-1 -: HDR_W] = HDR_BITS;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int j = 0; j < 3; j++) begin
                b = smp[ch][SAMPLE_W-1-8*j -: 8];
                idx = ch * 3 + j;
                raw[FRAME_W-1-HDR_W-idx*TOKEN_W -: TOKEN_W] = {1'b1, b[7:4], 1'b1, b[3:0]};
            end
        end
        for (int i = FRAME_W - 1; i >= 0; i--) begin
            nrzi_level = nrzi_level ^ raw[i];
            coded[i] = nrzi_level;
        end
        for (int k = 0; k < NUM_WORDS; k++) begin
            beat.line_word = coded[FRAME_W-1-k*WORD_W -: WORD_W];
            beat.frame_end = (k == NUM_WORDS - 1);
            beats_due.push_back(beat);
        end
    endfunction

    always @(posedge aclk) begin
        line_beat_t due;
        int         errs;
        errs = 0;
        if (!aresetn) begin
            beats_due.delete();
            nrzi_level = 1'b0;
            mismatch_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                encode_frame(frame_in);
            end
            if (m_valid && m_ready) begin
                if (beats_due.size() == 0) begin
                    $error("line word %h arrived with no frame pending", m_line_word);
                    errs++;
                end else begin
                    due = beats_due.pop_front();
                    if (m_line_word !== due.line_word) begin
                        $error("line_word: expected %h, actual %h", due.line_word, m_line_word);
                        errs++;
                    end
                    if (m_frame_end !== due.frame_end) begin
                        $error("frame_end: expected %b, actual %b", due.frame_end, m_frame_end);
                        errs++;
                    end
                end
            end
            mismatch_count <= mismatch_count + errs;
        end
        words_due <= beats_due.size();
    end

endmodule

/* tb/adat_frame_encoder_unit_test.sv */
// ---------------------------------------------------------------------------
// adat_frame_encoder_unit_test
// Drives frame requests into the ADAT frame encoder with random idling on
// both channels and gives the verdict from the line checker's counts.
// ---------------------------------------------------------------------------
module adat_frame_encoder_unit_test;
    import adat_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned DIRECTED_CNT = 12;
    localparam int unsigned PHASE_CNT    = 6;
    localparam int unsigned PHASE_FRAMES = 25;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    sample_arr_t frame_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_line_word;
    logic        m_frame_end;
    int          mismatch_count;
    int          words_due;
    bit          steady = 1'b0;
    int unsigned ready_hold = 0;
    int unsigned idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    adat_frame_encoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_0  (frame_data[0]),
        .s_sample_1  (frame_data[1]),
        .s_sample_2  (frame_data[2]),
        .s_sample_3  (frame_data[3]),
        .s_sample_4  (frame_data[4]),
        .s_sample_5  (frame_data[5]),
        .s_sample_6  (frame_data[6]),
        .s_sample_7  (frame_data[7]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_word (m_line_word),
        .m_frame_end (m_frame_end)
    );

    adat_line_checker line_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_0     (frame_data[0]),
        .s_sample_1     (frame_data[1]),
        .s_sample_2     (frame_data[2]),
        .s_sample_3     (frame_data[3]),
        .s_sample_4     (frame_data[4]),
        .s_sample_5     (frame_data[5]),
        .s_sample_6     (frame_data[6]),
        .s_sample_7     (frame_data[7]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_word    (m_line_word),
        .m_frame_end    (m_frame_end),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    // Mostly no gap, some short ones, a few long ones.
    function automatic int unsigned pick_gap(input bit no_idle);
        int unsigned r;
        r = $urandom_range(99);
        if (no_idle || r < 65) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    function automatic sample_arr_t directed_frame(input int n);
        sample_arr_t f;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            case (n)
                0, 2:    f[ch] = 24'h000000;
                1:       f[ch] = 24'hFFFFFF;
                3:       f[ch] = 24'hAAAAAA;
                4:       f[ch] = 24'h555555;
                5:       f[ch] = 24'hF0F0F0;
                6:       f[ch] = 24'h0F0F0F;
                7:       f[ch] = 24'h000001 << (ch * 3);
                8:       f[ch] = 24'h800000 >> ch;
                9:       f[ch] = ch[0] ? 24'hFFFFFF : 24'h000000;
                10:      f[ch] = {8'(ch), 8'(ch << 4), 8'(8'hFF - ch)};
                default: f[ch] = (ch == NUM_CH - 1) ? 24'h000001 : 24'h000000;
            endcase
        end
        return f;
    endfunction

    // Bias some bytes to all zeros or all ones so header-like runs show up.
    function automatic sample_arr_t random_frame();
        sample_arr_t f;
        int unsigned r;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int j = 0; j < 3; j++) begin
                r = $urandom_range(9);
                if (r == 0) begin
                    f[ch][8*j +: 8] = 8'h00;
                end else if (r == 1) begin
                    f[ch][8*j +: 8] = 8'hFF;
                end else begin
                    f[ch][8*j +: 8] = 8'($urandom);
                end
            end
        end
        return f;
    endfunction

    task automatic send_frame(input sample_arr_t f);
        int unsigned gap;
        gap = pick_gap(steady);
        if (gap != 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        frame_data = f;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_lines();
        @(negedge aclk);
        s_valid = 1'b0;
        do @(posedge aclk); while (words_due != 0);
    endtask

    // Result side: hold ready low for a random stall now and then.
    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
            ready_hold <= pick_gap(steady);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("adat_frame_encoder_unit regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int n = 0; n < DIRECTED_CNT; n++) begin
            steady = (n >= 8);
            send_frame(directed_frame(n));
        end
        steady = 1'b0;
        drain_lines();

        for (int p = 0; p < PHASE_CNT; p++) begin
            steady = (p == 1 || p == 4);
            if (p == 3) begin
                drain_lines();
            end
            for (int i = 0; i < PHASE_FRAMES; i++) begin
                send_frame(random_frame());
            end
        end
        steady = 1'b0;

        drain_lines();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && words_due == 0) begin
            $display("adat_frame_encoder_unit regression: pass");
        end else begin
            $display("adat_frame_encoder_unit regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/adat_pkg.sv
design/adat_enc_lane.sv
design/adat_enc_merge.sv
design/adat_frame_encoder_unit.sv
tb/adat_line_checker.sv
tb/adat_frame_encoder_unit_test.sv
